@@ rtl/sfbse_pkg.sv @@
`timescale 1ns / 1ps

package sfbse_pkg;

	// Channel and frame geometry
	localparam int unsigned PulseW      = 12;
	localparam int unsigned ChanN       = 8;
	localparam int unsigned ChanIdxW    = $clog2(ChanN);
	localparam int unsigned FrameBytesN = 16;
	localparam int unsigned DataBytesN  = 18;
	localparam int unsigned ByteIdxW    = $clog2(DataBytesN);
	localparam int unsigned FlagPartsN  = 8;
	localparam int unsigned FlagIdxW    = $clog2(FlagPartsN);

	// Configuration port
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 10;
	localparam logic [CfgIdxW-1:0] RegReceiver = 3'd0;
	localparam logic [CfgIdxW-1:0] RegFirstFlag = 3'd1;
	localparam logic [CfgIdxW-1:0] RegExtraFlag = 3'd2;
	localparam logic [CfgIdxW-1:0] RegInterval = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMode = 3'd4;
	localparam logic [9:0] IntervalReset = 10'd1000;

	// Pulse scaling: q = floor((w - 817) * 2048 / 1365) = (d * ScaleRecip) >> ScaleShift
	localparam logic [PulseW-1:0] PulseOffset = 12'd817;
	localparam int unsigned       RecipW      = 24;
	localparam logic [RecipW-1:0] ScaleRecip  = 24'd12585985;
	localparam int unsigned       ProdW       = PulseW + RecipW;
	localparam int unsigned       ScaleShift  = 23;
	localparam int unsigned       QuotW       = 13;
	localparam int unsigned       ClampW      = 14;
	localparam logic [ClampW-1:0] HalfOffset  = 14'd2048;
	localparam logic [ClampW-1:0] LowMin      = 14'd1;
	localparam logic [ClampW-1:0] LowMax      = 14'd2046;
	localparam logic [ClampW-1:0] UpMin       = 14'd2049;
	localparam logic [ClampW-1:0] UpMax       = 14'd4094;
	localparam logic [PulseW-1:0] FailsafeUpper = 12'd2048;
	localparam logic [7:0]        FailsafeFlag  = 8'h10;

	// Line coding
	localparam logic [7:0] FlagPattern = 8'h7E;
	localparam logic [2:0] StuffRun    = 3'd5;

	// Frame queue
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QPtrW      = $clog2(QueueDepth);
	localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

	// CRC16, nibble table plus multiple of the polynomial for the high nibble
	localparam logic [15:0] CrcPoly = 16'h1081;
	localparam logic [15:0] CrcNibble [16] = '{
		16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
		16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
	};

	typedef struct packed {
		logic [7:0] receiver_number;
		logic [7:0] first_flag_byte;
		logic [7:0] extra_flag_byte;
		logic [9:0] failsafe_interval;
		logic       sixteen_channel_mode;
	} cfg_t;

	typedef struct packed {
		logic [FrameBytesN*8-1:0] data_bytes;
		logic                     upper;
		logic                     failsafe;
	} frame_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
		logic [7:0]  v;
		logic [15:0] t;
		v = crc[15:8] ^ d;
		t = CrcNibble[v[3:0]] ^ (CrcPoly * {12'd0, v[7:4]});
		return {crc[7:0], 8'h00} ^ t;
	endfunction

endpackage

@@ rtl/sfbse_in_if.sv @@
`timescale 1ns / 1ps

interface sfbse_in_if import sfbse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PulseW-1:0] pulse_0;
	logic [PulseW-1:0] pulse_1;
	logic [PulseW-1:0] pulse_2;
	logic [PulseW-1:0] pulse_3;
	logic [PulseW-1:0] pulse_4;
	logic [PulseW-1:0] pulse_5;
	logic [PulseW-1:0] pulse_6;
	logic [PulseW-1:0] pulse_7;

	modport source (
		output valid, pulse_0, pulse_1, pulse_2, pulse_3,
		output pulse_4, pulse_5, pulse_6, pulse_7,
		input  ready
	);
	modport sink (
		input  valid, pulse_0, pulse_1, pulse_2, pulse_3,
		input  pulse_4, pulse_5, pulse_6, pulse_7,
		output ready
	);
endinterface

@@ rtl/sfbse_out_if.sv @@
`timescale 1ns / 1ps

interface sfbse_out_if import sfbse_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [15:0] line_word;
	logic [1:0]  byte_count;
	logic        frame_end;
	logic        upper_half_sent;
	logic        failsafe_sent;

	modport source (
		output valid, line_word, byte_count, frame_end, upper_half_sent, failsafe_sent,
		input  ready
	);
	modport sink (
		input  valid, line_word, byte_count, frame_end, upper_half_sent, failsafe_sent,
		output ready
	);
endinterface

@@ rtl/sfbse_front.sv @@
`timescale 1ns / 1ps

module sfbse_front import sfbse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	sfbse_in_if.sink    in_ch,
	output logic        push_valid,
	input  logic        push_ready,
	output frame_t      push_frame
);

	typedef enum logic [2:0] {
		F_IDLE  = 3'b001,
		F_SCALE = 3'b010,
		F_PUSH  = 3'b100
	} front_state_t;

	front_state_t        state_q;
	logic [ChanIdxW-1:0] chan_q;
	logic                phase_q;
	logic [9:0]          frame_cnt_q;
	logic                upper_half_q;
	logic                upper_q;
	logic                failsafe_q;
	logic [PulseW-1:0]   pulse_q [ChanN];
	logic [PulseW-1:0]   ch_q [ChanN];
	logic [ProdW-1:0]    prod_s1;
	logic                pos_s1;

	logic                accept;
	logic [9:0]          cnt_inc;
	logic                fs_now;
	logic                cnt_wrap;
	logic [PulseW-1:0]   pulse_cur;
	logic [PulseW-1:0]   diff;
	logic [QuotW-1:0]    quot;
	logic [ClampW-1:0]   shifted;
	logic [ClampW-1:0]   lo_lim;
	logic [ClampW-1:0]   hi_lim;
	logic [ClampW-1:0]   clamped;
	logic [PulseW-1:0]   chan_val;

	assign in_ch.ready = (state_q == F_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Failsafe decision on the incremented frame count
	assign cnt_inc  = frame_cnt_q + 10'd1;
	assign fs_now   = (cnt_inc >= cfg.failsafe_interval);
	assign cnt_wrap = fs_now && (!cfg.sixteen_channel_mode || (cnt_inc > cfg.failsafe_interval));

	// Scale stage one: offset and reciprocal multiply
	assign pulse_cur = pulse_q[chan_q];
	assign diff      = pulse_cur - PulseOffset;

	// Scale stage two: add half offset in the upper half and clamp, or take failsafe values
	always_comb begin
		quot    = prod_s1[ScaleShift +: QuotW];
		shifted = upper_q ? ({1'b0, quot} + HalfOffset) : {1'b0, quot};
		lo_lim  = upper_q ? UpMin : LowMin;
		hi_lim  = upper_q ? UpMax : LowMax;
		if (!pos_s1 || (shifted < lo_lim)) begin
			clamped = lo_lim;
		end else if (shifted > hi_lim) begin
			clamped = hi_lim;
		end else begin
			clamped = shifted;
		end
		if (failsafe_q) begin
			chan_val = upper_q ? FailsafeUpper : '0;
		end else begin
			chan_val = clamped[PulseW-1:0];
		end
	end

	// Assemble the sixteen data bytes of the frame
	always_comb begin
		push_frame.data_bytes        = '0;
		push_frame.data_bytes[7:0]   = cfg.receiver_number;
		push_frame.data_bytes[15:8]  = cfg.first_flag_byte | (failsafe_q ? FailsafeFlag : 8'h00);
		push_frame.data_bytes[23:16] = 8'h00;
		for (int p = 0; p < ChanN / 2; p++) begin
			push_frame.data_bytes[(3 + 3 * p) * 8 +: 8] = ch_q[2 * p][7:0];
			push_frame.data_bytes[(4 + 3 * p) * 8 +: 8] = {ch_q[2 * p + 1][3:0], ch_q[2 * p][11:8]};
			push_frame.data_bytes[(5 + 3 * p) * 8 +: 8] = ch_q[2 * p + 1][11:4];
		end
		push_frame.data_bytes[(FrameBytesN - 1) * 8 +: 8] = cfg.extra_flag_byte;
		push_frame.upper    = upper_q;
		push_frame.failsafe = failsafe_q;
	end

	assign push_valid = (state_q == F_PUSH);

	// Sequence accept, channel scaling and hand-over to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			chan_q       <= '0;
			phase_q      <= 1'b0;
			frame_cnt_q  <= '0;
			upper_half_q <= 1'b0;
			upper_q      <= 1'b0;
			failsafe_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						frame_cnt_q  <= cnt_wrap ? 10'd0 : cnt_inc;
						failsafe_q   <= fs_now;
						upper_q      <= upper_half_q;
						upper_half_q <= cfg.sixteen_channel_mode ? ~upper_half_q : 1'b0;
						chan_q       <= '0;
						phase_q      <= 1'b0;
						state_q      <= F_SCALE;
					end
				end
				F_SCALE: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (chan_q == ChanIdxW'(ChanN - 1)) begin
							state_q <= F_PUSH;
						end else begin
							chan_q <= chan_q + 1'b1;
						end
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Hold pulses, product and channel values
	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_q[0] <= in_ch.pulse_0;
			pulse_q[1] <= in_ch.pulse_1;
			pulse_q[2] <= in_ch.pulse_2;
			pulse_q[3] <= in_ch.pulse_3;
			pulse_q[4] <= in_ch.pulse_4;
			pulse_q[5] <= in_ch.pulse_5;
			pulse_q[6] <= in_ch.pulse_6;
			pulse_q[7] <= in_ch.pulse_7;
		end
		if ((state_q == F_SCALE) && !phase_q) begin
			prod_s1 <= {{RecipW{1'b0}}, diff} * {{PulseW{1'b0}}, ScaleRecip};
			pos_s1  <= (pulse_cur > PulseOffset);
		end
		if ((state_q == F_SCALE) && phase_q) begin
			ch_q[chan_q] <= chan_val;
		end
	end

	// A finished frame leaves the front before the next item is taken
	a_push_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> in_ch.ready)
		else $error("front not ready after hand-over");

endmodule

@@ rtl/sfbse_queue.sv @@
`timescale 1ns / 1ps

module sfbse_queue import sfbse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  frame_t push_frame,
	output logic   head_valid,
	output frame_t head_frame,
	input  logic   pop
);

	frame_t           ent_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push;

	assign push_ready = (count_q != QCntW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_frame = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed frames
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_frame;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("frame popped from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCntW'(QueueDepth)) && !pop |=> (count_q == QCntW'(QueueDepth)))
		else $error("full queue lost an entry without a pop");

endmodule

@@ rtl/sfbse_back.sv @@
`timescale 1ns / 1ps

module sfbse_back import sfbse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  frame_t     head_frame,
	output logic       pop,
	sfbse_out_if.source out_ch
);

	typedef enum logic [3:0] {
		P_FLAG1 = 4'b0001,
		P_DATA  = 4'b0010,
		P_FLAG2 = 4'b0100,
		P_PAD   = 4'b1000
	} phase_t;

	phase_t              phase_q;
	logic [FlagIdxW-1:0] sym_q;
	logic [ByteIdxW-1:0] byte_idx_q;
	logic [2:0]          bit_idx_q;
	logic [7:0]          cur_byte_q;
	logic                stuff_q;
	logic [2:0]          ones_q;
	logic [1:0]          step_q;
	logic [15:0]         crc_q;
	logic [7:0]          shift_q;
	logic [2:0]          fill_q;
	logic                pend_valid_q;
	logic [7:0]          pend_q;
	logic                word_valid_q;
	logic [15:0]         word_q;
	logic [1:0]          count_q;
	logic                end_q;
	logic                upper_q;
	logic                fs_q;

	logic                adv;
	logic                part_val;
	logic                line_bit;
	logic                part_end;
	logic [7:0]          new_byte;
	logic                byte_done;
	logic                frame_done;
	logic                emit;
	logic [ByteIdxW-1:0] nb_idx;
	logic [7:0]          nb_byte;
	logic [7:0]          first_byte;
	logic [2:0]          ones_inc;

	assign adv = head_valid && (!word_valid_q || out_ch.ready);

	// Current line part and line bit
	always_comb begin
		unique case (phase_q)
			P_FLAG1, P_FLAG2: part_val = FlagPattern[sym_q];
			P_DATA:           part_val = stuff_q ? 1'b0 : cur_byte_q[bit_idx_q];
			P_PAD:            part_val = 1'b1;
			default:          part_val = 1'b0;
		endcase
		line_bit = (phase_q == P_PAD) ? 1'b1 : (step_q != 2'd0);
		part_end = ((step_q == 2'd1) && !part_val) || (step_q == 2'd2);
	end

	assign new_byte   = {line_bit, shift_q[7:1]};
	assign byte_done  = (fill_q == 3'd7);
	assign frame_done = byte_done && ((phase_q == P_PAD) ||
		((phase_q == P_FLAG2) && part_end && (sym_q == FlagIdxW'(FlagPartsN - 1))));
	assign emit       = byte_done && (pend_valid_q || frame_done);
	assign pop        = adv && frame_done;
	assign ones_inc   = ones_q + 3'd1;

	// Next data byte: frame bytes, then the CRC high and low bytes
	assign nb_idx     = byte_idx_q + 1'b1;
	assign first_byte = head_frame.data_bytes[7:0];
	always_comb begin
		if (nb_idx < ByteIdxW'(FrameBytesN)) begin
			nb_byte = head_frame.data_bytes[{nb_idx[3:0], 3'b000} +: 8];
		end else if (nb_idx == ByteIdxW'(FrameBytesN)) begin
			nb_byte = crc_q[15:8];
		end else begin
			nb_byte = crc_q[7:0];
		end
	end

	// Walk flag, stuffed data, closing flag and padding one line bit a cycle unless stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= P_FLAG1;
			sym_q        <= '0;
			byte_idx_q   <= '0;
			bit_idx_q    <= '0;
			stuff_q      <= 1'b0;
			ones_q       <= '0;
			step_q       <= '0;
			fill_q       <= '0;
			pend_valid_q <= 1'b0;
			word_valid_q <= 1'b0;
		end else begin
			if (adv && emit) begin
				word_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				word_valid_q <= 1'b0;
			end
			if (adv) begin
				fill_q <= fill_q + 3'd1;
				if (byte_done) begin
					pend_valid_q <= !pend_valid_q && !frame_done;
				end
				if (phase_q != P_PAD) begin
					step_q <= part_end ? 2'd0 : step_q + 2'd1;
				end
				unique case (phase_q)
					P_FLAG1: begin
						if (part_end) begin
							if (sym_q == FlagIdxW'(FlagPartsN - 1)) begin
								phase_q    <= P_DATA;
								sym_q      <= '0;
								byte_idx_q <= '0;
								bit_idx_q  <= 3'd7;
								stuff_q    <= 1'b0;
								ones_q     <= '0;
							end else begin
								sym_q <= sym_q + 1'b1;
							end
						end
					end
					P_DATA: begin
						if (part_end) begin
							if (!stuff_q && part_val && (ones_inc == StuffRun)) begin
								ones_q  <= '0;
								stuff_q <= 1'b1;
							end else begin
								if (stuff_q) begin
									stuff_q <= 1'b0;
								end else begin
									ones_q <= part_val ? ones_inc : 3'd0;
								end
								if (bit_idx_q == 3'd0) begin
									bit_idx_q <= 3'd7;
									if (byte_idx_q == ByteIdxW'(DataBytesN - 1)) begin
										phase_q <= P_FLAG2;
										sym_q   <= '0;
									end else begin
										byte_idx_q <= nb_idx;
									end
								end else begin
									bit_idx_q <= bit_idx_q - 3'd1;
								end
							end
						end
					end
					P_FLAG2: begin
						if (part_end) begin
							if (sym_q == FlagIdxW'(FlagPartsN - 1)) begin
								sym_q   <= '0;
								phase_q <= frame_done ? P_FLAG1 : P_PAD;
							end else begin
								sym_q <= sym_q + 1'b1;
							end
						end
					end
					P_PAD: begin
						if (frame_done) begin
							phase_q <= P_FLAG1;
						end
					end
					default: phase_q <= P_FLAG1;
				endcase
			end
		end
	end

	// Shift register, current byte, CRC and output word payload
	always_ff @(posedge clk) begin
		if (adv) begin
			shift_q <= new_byte;
			if (byte_done && !pend_valid_q) begin
				pend_q <= new_byte;
			end
			if ((phase_q == P_FLAG1) && part_end && (sym_q == FlagIdxW'(FlagPartsN - 1))) begin
				cur_byte_q <= first_byte;
				crc_q      <= crc_step(16'h0000, first_byte);
			end
			if ((phase_q == P_DATA) && part_end && (bit_idx_q == 3'd0) &&
				!(!stuff_q && part_val && (ones_inc == StuffRun)) &&
				(byte_idx_q != ByteIdxW'(DataBytesN - 1))) begin
				cur_byte_q <= nb_byte;
				if (nb_idx < ByteIdxW'(FrameBytesN)) begin
					crc_q <= crc_step(crc_q, nb_byte);
				end
			end
			if (emit) begin
				word_q  <= pend_valid_q ? {new_byte, pend_q} : {8'h00, new_byte};
				count_q <= pend_valid_q ? 2'd2 : 2'd1;
				end_q   <= frame_done;
				upper_q <= head_frame.upper;
				fs_q    <= head_frame.failsafe;
			end
		end
	end

	assign out_ch.valid           = word_valid_q;
	assign out_ch.line_word       = word_q;
	assign out_ch.byte_count      = count_q;
	assign out_ch.frame_end       = end_q;
	assign out_ch.upper_half_sent = upper_q;
	assign out_ch.failsafe_sent   = fs_q;

	a_single_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid_q |-> ((count_q == 2'd2) || end_q))
		else $error("single-byte word before the end of a frame");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_DATA) |-> (ones_q < StuffRun))
		else $error("ones run reached the stuffing limit");

	a_pop_empties_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (!pend_valid_q && (fill_q == 3'd0)))
		else $error("bits left over after the end of a frame");

endmodule

@@ rtl/servo_frame_bit_stuffed_encoder_unit.sv @@
`timescale 1ns / 1ps
// Flow: the front scales and packs a frame channel by channel and waits while the
//   queue is full; the back part serialises the frame at the head of the queue.
// The frame rate is set by the back serialiser, which produces one line bit per cycle
//   while the output does not stall and at most 64 line bytes a frame; the front
//   takes the next item meanwhile.
// Reset (arst_n low): queue empty, counters and half select cleared, registers
//   at their reset values (failsafe interval 1000).

module servo_frame_bit_stuffed_encoder_unit import sfbse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	sfbse_in_if.sink            in_ch,
	sfbse_out_if.source         out_ch
);

	cfg_t   cfg_q;
	logic   push_valid;
	logic   push_ready;
	frame_t push_frame;
	logic   head_valid;
	frame_t head_frame;
	logic   pop;

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receiver_number      <= '0;
			cfg_q.first_flag_byte      <= '0;
			cfg_q.extra_flag_byte      <= '0;
			cfg_q.failsafe_interval    <= IntervalReset;
			cfg_q.sixteen_channel_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegReceiver:  cfg_q.receiver_number      <= cfg_data[7:0];
				RegFirstFlag: cfg_q.first_flag_byte      <= cfg_data[7:0];
				RegExtraFlag: cfg_q.extra_flag_byte      <= cfg_data[7:0];
				RegInterval:  cfg_q.failsafe_interval    <= cfg_data[9:0];
				RegMode:      cfg_q.sixteen_channel_mode <= cfg_data[0];
				default:      cfg_q                      <= cfg_q;
			endcase
		end
	end

	sfbse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame)
	);

	sfbse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.head_valid (head_valid),
		.head_frame (head_frame),
		.pop        (pop)
	);

	sfbse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_frame (head_frame),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
